// ===== rtl/pwm_pulse_width_classifier_assert.svh =====
// assertion macros used by pwc_core
`ifndef PWM_PULSE_WIDTH_CLASSIFIER_ASSERT_SVH
`define PWM_PULSE_WIDTH_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwc_pkg.sv =====
package pwc_pkg;

    localparam int TIME_W  = 32;
    localparam int WIDTH_W = 16;
    localparam int TMO_W   = 24;
    localparam int CLASS_W = 2;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_AW-1:0] REG_MIN_PERIOD = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_PERIOD = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TIMEOUT    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_LOW_THR    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_HIGH_THR   = 3'd4;

    localparam logic [WIDTH_W-1:0] MIN_PERIOD_RST = 16'd500;
    localparam logic [WIDTH_W-1:0] MAX_PERIOD_RST = 16'd2500;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST    = 24'd100000;
    localparam logic [WIDTH_W-1:0] LOW_THR_RST    = 16'd1250;
    localparam logic [WIDTH_W-1:0] HIGH_THR_RST   = 16'd1750;

    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LOW     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NEUTRAL = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HIGH    = 2'd3;

    typedef struct packed {
        logic [WIDTH_W-1:0] min_period;
        logic [WIDTH_W-1:0] max_period;
        logic [TMO_W-1:0]   timeout;
        logic [WIDTH_W-1:0] low_thr;
        logic [WIDTH_W-1:0] high_thr;
    } t_cfg;

endpackage

// ===== rtl/pwc_cfg.sv =====
module pwc_cfg
    import pwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_PERIOD: n_cfg.min_period = i_cfg_wdata[WIDTH_W-1:0];
                REG_MAX_PERIOD: n_cfg.max_period = i_cfg_wdata[WIDTH_W-1:0];
                REG_TIMEOUT:    n_cfg.timeout    = i_cfg_wdata[TMO_W-1:0];
                REG_LOW_THR:    n_cfg.low_thr    = i_cfg_wdata[WIDTH_W-1:0];
                REG_HIGH_THR:   n_cfg.high_thr   = i_cfg_wdata[WIDTH_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period <= MIN_PERIOD_RST;
            r_cfg.max_period <= MAX_PERIOD_RST;
            r_cfg.timeout    <= TIMEOUT_RST;
            r_cfg.low_thr    <= LOW_THR_RST;
            r_cfg.high_thr   <= HIGH_THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pwc_core.sv =====
module pwc_core
    import pwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [TIME_W-1:0]  i_time,
    input  logic               i_pin_level,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CLASS_W-1:0] o_class,
    output logic [WIDTH_W-1:0] o_width
);

`include "pwm_pulse_width_classifier_assert.svh"

    // input stage
    logic               r_in_valid;
    logic               r_in_cmd;
    logic [TIME_W-1:0]  r_in_time;
    logic               r_in_level;

    // tracking state
    logic [TIME_W-1:0]  r_prev_edge;
    logic [TIME_W-1:0]  r_last_update;
    logic [WIDTH_W-1:0] r_width;

    // result stage
    logic               r_out_valid;
    logic [CLASS_W-1:0] r_out_class;
    logic [WIDTH_W-1:0] r_out_width;

    logic               advance;
    logic               in_hs;
    logic [TIME_W-1:0]  edge_diff;
    logic [TIME_W-1:0]  upd_diff;
    logic               in_window;
    logic               timed_out;
    logic [WIDTH_W:0]   avg_sum;
    logic [WIDTH_W-1:0] n_width;
    logic [TIME_W-1:0]  n_prev_edge;
    logic [TIME_W-1:0]  n_last_update;
    logic [CLASS_W-1:0] n_class;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_hs   = i_valid && o_ready;

    assign edge_diff = r_in_time - r_prev_edge;
    assign upd_diff  = r_in_time - r_last_update;
    assign in_window = (edge_diff >= {{(TIME_W-WIDTH_W){1'b0}}, i_cfg.min_period})
                    && (edge_diff <= {{(TIME_W-WIDTH_W){1'b0}}, i_cfg.max_period});
    assign timed_out = upd_diff > {{(TIME_W-TMO_W){1'b0}}, i_cfg.timeout};
    assign avg_sum   = {1'b0, r_width} + {1'b0, edge_diff[WIDTH_W-1:0]};

    always_comb begin
        n_width       = r_width;
        n_prev_edge   = r_prev_edge;
        n_last_update = r_last_update;
        if (r_in_cmd == CMD_EDGE) begin
            n_prev_edge = r_in_time;
            if (!r_in_level) begin
                n_last_update = r_in_time;
                if (!in_window) begin
                    n_width = '0;
                end else if (r_width == '0) begin
                    n_width = edge_diff[WIDTH_W-1:0];
                end else begin
                    n_width = avg_sum[WIDTH_W:1];
                end
            end
        end else if (timed_out) begin
            n_width = '0;
        end
    end

    always_comb begin
        if (n_width == '0) begin
            n_class = CLASS_NONE;
        end else if (n_width < i_cfg.low_thr) begin
            n_class = CLASS_LOW;
        end else if (n_width > i_cfg.high_thr) begin
            n_class = CLASS_HIGH;
        end else begin
            n_class = CLASS_NEUTRAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_edge   <= '0;
            r_last_update <= '0;
            r_width       <= '0;
        end else begin
            if (in_hs) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_prev_edge   <= n_prev_edge;
                r_last_update <= n_last_update;
                r_width       <= n_width;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_hs) begin
            r_in_cmd   <= i_command;
            r_in_time  <= i_time;
            r_in_level <= i_pin_level;
        end
        if (advance) begin
            r_out_class <= n_class;
            r_out_width <= n_width;
        end
    end

    assign o_valid = r_out_valid;
    assign o_class = r_out_class;
    assign o_width = r_out_width;

    `PWC_ASSERT_NOW(a_class_none_iff_zero, r_out_valid,
        (r_out_width == '0) == (r_out_class == CLASS_NONE), "class and width disagree")
    `PWC_ASSERT_NEXT(a_edge_time_taken, advance && (r_in_cmd == CMD_EDGE),
        r_prev_edge == $past(r_in_time), "edge time not recorded")
    `PWC_ASSERT_NEXT(a_query_no_load, advance && (r_in_cmd == CMD_QUERY),
        (r_width == '0) || (r_width == $past(r_width)), "query changed width")
    `PWC_ASSERT_NEXT(a_held_item_kept, r_in_valid && !advance,
        r_in_valid && $stable(r_in_time), "stalled item lost")

endmodule

// ===== rtl/pwm_pulse_width_classifier.sv =====
// channel     dir  signals                            contents
// s_axis      in   i_s_axis_tvalid/o_s_axis_tready    tdata: time_us, pin_level; tuser: command
// m_axis      out  o_m_axis_tvalid/i_m_axis_tready    tdata: signal_class, width_us
// cfg         in   i_cfg_we/i_cfg_addr/i_cfg_wdata    register writes, no read-back
//
// one word per cycle sustained while i_m_axis_tready holds; a new word is taken while the last is in flight
// an accepted word passes the input register, then the result register; state updates in one pass
// a full result register stalls the input register, which still holds one more word
// synchronous active-low reset restores register defaults and clears the width
module pwm_pulse_width_classifier
    import pwc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // time_us[31:0], pin_level[32], zero pad
    input  logic                   i_s_axis_tuser,   // command[0]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // signal_class[1:0], width_us[17:2], zero pad
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [CFG_DW-1:0]      i_cfg_wdata
);

    t_cfg               cfg;
    logic [CLASS_W-1:0] out_class;
    logic [WIDTH_W-1:0] out_width;

    pwc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pwc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_command   (i_s_axis_tuser),
        .i_time      (i_s_axis_tdata[TIME_W-1:0]),
        .i_pin_level (i_s_axis_tdata[TIME_W]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_class     (out_class),
        .o_width     (out_width)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-CLASS_W-WIDTH_W){1'b0}}, out_width, out_class};

endmodule

// ===== tb/pwm_pulse_width_classifier_tb.sv =====
module pwm_pulse_width_classifier_tb;
    import pwc_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] stamp;
        logic              level;
    } t_pin_event;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [WIDTH_W-1:0] width;
    } t_reading;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // time_us[31:0], pin_level[32], zero pad
    logic                   i_s_axis_tuser = 1'b0; // command[0]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // signal_class[1:0], width_us[17:2], zero pad
    logic                   i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [CFG_DW-1:0]      i_cfg_wdata = '0;

    t_pin_event  pin_event_q[$];
    t_reading    reading_q[$];
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_cnt = 0;

    // classifier model: registers and state
    logic [WIDTH_W-1:0] min_period = MIN_PERIOD_RST;
    logic [WIDTH_W-1:0] max_period = MAX_PERIOD_RST;
    logic [TMO_W-1:0]   timeout = TIMEOUT_RST;
    logic [WIDTH_W-1:0] low_thr = LOW_THR_RST;
    logic [WIDTH_W-1:0] high_thr = HIGH_THR_RST;
    logic [TIME_W-1:0]  prev_edge_us = '0;
    logic [TIME_W-1:0]  last_fall_us = '0;
    logic [WIDTH_W-1:0] held_width = '0;

    logic [TIME_W-1:0]  now_us = 32'd300000;

    pwm_pulse_width_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [CLASS_W-1:0] width_class(input logic [WIDTH_W-1:0] w);
        if (w == '0)
            return CLASS_NONE;
        if (w < low_thr)
            return CLASS_LOW;
        if (w > high_thr)
            return CLASS_HIGH;
        return CLASS_NEUTRAL;
    endfunction

    always @(posedge i_clk) begin : driver
        t_pin_event ev;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pin_event_q.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
                ev = pin_event_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= IN_TDATA_W'({ev.level, ev.stamp});
                i_s_axis_tuser  <= ev.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  gap;
        logic [WIDTH_W:0]   sum;
        t_reading           got;
        t_reading           want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                stamp = i_s_axis_tdata[TIME_W-1:0];
                if (i_s_axis_tuser == CMD_EDGE) begin
                    gap = stamp - prev_edge_us;
                    prev_edge_us = stamp;
                    if (!i_s_axis_tdata[TIME_W]) begin
                        last_fall_us = stamp;
                        if (gap >= TIME_W'(min_period) && gap <= TIME_W'(max_period)) begin
                            if (held_width == '0) begin
                                held_width = gap[WIDTH_W-1:0];
                            end else begin
                                sum = {1'b0, held_width} + {1'b0, gap[WIDTH_W-1:0]};
                                held_width = sum[WIDTH_W:1];
                            end
                        end else begin
                            held_width = '0;
                        end
                    end
                end else begin
                    gap = stamp - last_fall_us;
                    if (gap > TIME_W'(timeout))
                        held_width = '0;
                end
                want.cls = width_class(held_width);
                want.width = held_width;
                reading_q.push_back(want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.cls = o_m_axis_tdata[CLASS_W-1:0];
                got.width = o_m_axis_tdata[CLASS_W +: WIDTH_W];
                if (reading_q.size() == 0) begin
                    $display("%0t: unexpected word, class %0d width %0d",
                             $time, got.cls, got.width);
                    fail_cnt++;
                end else begin
                    want = reading_q.pop_front();
                    if (got.cls !== want.cls) begin
                        $display("%0t: class mismatch, expected %0d actual %0d",
                                 $time, want.cls, got.cls);
                        fail_cnt++;
                    end
                    if (got.width !== want.width) begin
                        $display("%0t: width mismatch, expected %0d actual %0d",
                                 $time, want.width, got.width);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic put(input logic cmd, input logic [TIME_W-1:0] stamp, input logic level);
        t_pin_event ev;
        ev.cmd = cmd;
        ev.stamp = stamp;
        ev.level = level;
        pin_event_q.push_back(ev);
    endtask

    task automatic wait_idle();
        while (pin_event_q.size() != 0 || i_s_axis_tvalid || reading_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            REG_MIN_PERIOD: min_period = data[WIDTH_W-1:0];
            REG_MAX_PERIOD: max_period = data[WIDTH_W-1:0];
            REG_TIMEOUT:    timeout = data[TMO_W-1:0];
            REG_LOW_THR:    low_thr = data[WIDTH_W-1:0];
            REG_HIGH_THR:   high_thr = data[WIDTH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // upper bits of the 16-bit registers are random and must be dropped
    task automatic set_cfg(input logic [WIDTH_W-1:0] mn, input logic [WIDTH_W-1:0] mx,
                           input logic [TMO_W-1:0] tmo, input logic [WIDTH_W-1:0] lo,
                           input logic [WIDTH_W-1:0] hi);
        wait_idle();
        write_reg(REG_MIN_PERIOD, {8'($urandom), mn});
        write_reg(REG_MAX_PERIOD, {8'($urandom), mx});
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_LOW_THR, {8'($urandom), lo});
        write_reg(REG_HIGH_THR, {8'($urandom), hi});
        write_reg(CFG_AW'(REG_HIGH_THR + 1 + $urandom_range(2, 0)), CFG_DW'($urandom));
    endtask

    task automatic add_random(input int unsigned count);
        int unsigned       n;
        int unsigned       pick;
        logic [TIME_W-1:0] w;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99, 0);
            if ($urandom_range(49, 0) == 0)
                now_us = $urandom();
            if (pick < 70) begin
                case ($urandom_range(9, 0))
                    0: w = min_period - 1;
                    1: w = max_period + 1;
                    2: w = $urandom_range(70000, 0);
                    default: w = $urandom_range(max_period, min_period);
                endcase
                put(CMD_EDGE, now_us, 1'b1);
                put(CMD_EDGE, now_us + w, 1'b0);
                n += 2;
                if ($urandom_range(3, 0) == 0) begin
                    put(CMD_QUERY, now_us + w + $urandom_range(5000, 0),
                        1'($urandom_range(1, 0)));
                    n++;
                end
                now_us += w + $urandom_range(30000, 1000);
            end else if (pick < 85) begin
                // query within 20 us of now_us plus the timeout
                put(CMD_QUERY, now_us + timeout + $urandom_range(40, 0) - 20,
                    1'($urandom_range(1, 0)));
                n++;
            end else begin
                put(1'($urandom_range(1, 0)), $urandom(), 1'($urandom_range(1, 0)));
                n++;
            end
        end
    endtask

    initial begin
        int unsigned        ph;
        logic [WIDTH_W-1:0] mn;
        logic [WIDTH_W-1:0] mx;
        logic [WIDTH_W-1:0] lo;
        logic [WIDTH_W-1:0] hi;
        send_gap_pct = 10;
        recv_stall_pct = 81;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers
        put(CMD_QUERY, 32'd0, 1'b1);
        put(CMD_EDGE, 32'd1000, 1'b1);
        put(CMD_EDGE, 32'd2500, 1'b0);
        put(CMD_EDGE, 32'd21000, 1'b1);
        put(CMD_EDGE, 32'd22000, 1'b0);
        put(CMD_EDGE, 32'd24000, 1'b0);
        put(CMD_EDGE, 32'd40000, 1'b1);
        put(CMD_EDGE, 32'd42500, 1'b0);
        put(CMD_EDGE, 32'd60000, 1'b1);
        put(CMD_EDGE, 32'd60499, 1'b0);
        put(CMD_EDGE, 32'd70000, 1'b1);
        put(CMD_EDGE, 32'd70500, 1'b0);
        put(CMD_QUERY, 32'd170500, 1'b0);
        put(CMD_QUERY, 32'd170501, 1'b1);
        put(CMD_EDGE, 32'hFFFF_FC00, 1'b1);
        put(CMD_EDGE, 32'h0000_01F4, 1'b0);
        put(CMD_EDGE, 32'hFFFF_FFFF, 1'b0);
        put(CMD_EDGE, 32'h0000_0100, 1'b1);
        put(CMD_EDGE, 32'h0000_07D6, 1'b0);

        // widest window, zero timeout, low above high
        set_cfg(16'd0, 16'hFFFF, 24'd0, 16'hFFFF, 16'd0);
        put(CMD_EDGE, 32'd100, 1'b1);
        put(CMD_EDGE, 32'd100, 1'b0);
        put(CMD_EDGE, 32'd65635, 1'b0);
        put(CMD_QUERY, 32'd65635, 1'b0);
        put(CMD_QUERY, 32'd65636, 1'b1);
        put(CMD_EDGE, 32'd131171, 1'b0);

        // empty window
        set_cfg(16'd3000, 16'd1000, 24'hFFFFFF, 16'd1250, 16'd1750);
        put(CMD_EDGE, 32'd200000, 1'b1);
        put(CMD_EDGE, 32'd202000, 1'b0);

        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_gap_pct = 81;
                recv_stall_pct = 10;
            end else if (ph == 4) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            if (ph == 0) begin
                set_cfg(MIN_PERIOD_RST, MAX_PERIOD_RST, TIMEOUT_RST, LOW_THR_RST,
                        HIGH_THR_RST);
            end else if (ph == 1) begin
                set_cfg(16'd0, 16'hFFFF, 24'hFFFFFF, 16'd0, 16'hFFFF);
            end else begin
                mn = WIDTH_W'($urandom_range(2000, 0));
                mx = mn + WIDTH_W'($urandom_range(3000, 0));
                lo = WIDTH_W'($urandom_range(mx, mn));
                hi = WIDTH_W'($urandom_range(mx, mn));
                if ($urandom_range(3, 0) == 0)
                    set_cfg(mx, mn, TMO_W'($urandom_range(300000, 0)), hi, lo);
                else
                    set_cfg(mn, mx, TMO_W'($urandom_range(300000, 0)), lo, hi);
            end
            add_random(175);
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0 && reading_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
